@@ rtl/core/robb_pkg.sv @@
// Shared types and constants for the ray versus oriented box slab test.
// Used by the channel interfaces, the divider and the top level.
`default_nettype none

package robb_pkg;

  // Q24.24 signed fixed point
  localparam int unsigned Q_W    = 48;
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned HALF_W = 24;

  typedef logic signed [Q_W-1:0] q48_t;
  typedef logic signed [Q_W:0]   q49_t;

  // Dot product accumulator: three 96-bit products plus sign headroom
  localparam int unsigned ACC_W     = 100;
  // Six products, four 24x24 partial products each
  localparam int unsigned MUL_STEPS = 24;
  // Quotient bits of a 49-bit numerator scaled by 2^24
  localparam int unsigned DIV_STEPS = Q_W + 1 + FRAC_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned EPS_W      = 25;
  localparam int unsigned FAR_W      = 47;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FAR      = 3'd7;

  // Register reset values: direction (0, 0, 1.0), epsilon about 0.001,
  // far limit 100000.0
  localparam q48_t               DIR_Z_RST = 48'sd16777216;
  localparam logic [EPS_W-1:0]   EPS_RST   = 25'd16777;
  localparam logic [FAR_W-1:0]   FAR_RST   = 47'd1677721600000;

  // Saturation limits
  localparam q48_t Q48_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q48_t Q48_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Divider request and response
  typedef struct packed {
    logic start;
    q49_t num;
    q48_t den;
  } robb_div_req_t;

  typedef struct packed {
    logic done;
    q48_t quo;
  } robb_div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/robb_axis_if.sv @@
// Input channel: one box axis per transaction.
// Depends on robb_pkg for the Q24.24 field type.
`default_nettype none

interface robb_axis_if;
  logic          valid;
  logic          ready;
  robb_pkg::q48_t axis_x;
  robb_pkg::q48_t axis_y;
  robb_pkg::q48_t axis_z;
  robb_pkg::q48_t box_pos_x;
  robb_pkg::q48_t box_pos_y;
  robb_pkg::q48_t box_pos_z;
  robb_pkg::q48_t slab_low;
  robb_pkg::q48_t slab_high;
  logic          last_axis;

  modport source (
    output valid, axis_x, axis_y, axis_z, box_pos_x, box_pos_y, box_pos_z,
           slab_low, slab_high, last_axis,
    input  ready
  );

  modport sink (
    input  valid, axis_x, axis_y, axis_z, box_pos_x, box_pos_y, box_pos_z,
           slab_low, slab_high, last_axis,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/robb_result_if.sv @@
// Output channel: one hit verdict per closed box.
// Depends on robb_pkg for the Q24.24 field type.
`default_nettype none

interface robb_result_if;
  logic           valid;
  logic           ready;
  logic           hit;
  robb_pkg::q48_t entry_distance;

  modport source (
    output valid, hit, entry_distance,
    input  ready
  );

  modport sink (
    input  valid, hit, entry_distance,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/robb_div.sv @@
// Radix-2 restoring divider: (num * 2^24) / den, truncated toward zero,
// saturated to 48 bits signed. Depends on robb_pkg.
`default_nettype none

module robb_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  robb_pkg::robb_div_req_t req_i,
  output robb_pkg::robb_div_rsp_t rsp_o
);
  import robb_pkg::*;

  localparam int unsigned DQ_W  = DIV_STEPS;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [Q_W-1:0]   rem_q, rem_d;
  logic [DQ_W-1:0]  dq_q, dq_d;
  logic [Q_W-1:0]   den_q, den_d;
  logic             neg_q, neg_d;
  q48_t             quo_q, quo_d;

  logic [Q_W:0]     num_mag;
  logic [Q_W-1:0]   den_mag;
  logic [Q_W:0]     rem_sh;
  logic [Q_W+1:0]   diff;
  logic             fits;
  logic             over;
  logic [Q_W-1:0]   q_mag;

  // Magnitudes of the request operands
  always_comb begin
    num_mag = req_i.num[Q_W] ? (Q_W+1)'(-req_i.num) : req_i.num;
    den_mag = req_i.den[Q_W-1] ? Q_W'(-req_i.den) : req_i.den;
  end

  // One quotient bit per step
  always_comb begin
    rem_sh = {rem_q, dq_q[DQ_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    fits   = ~diff[Q_W+1];
  end

  // Clamp the finished quotient to the signed 48-bit range
  always_comb begin
    if (neg_q) begin
      over = (|dq_q[DQ_W-1:Q_W]) | (dq_q[Q_W-1] & (|dq_q[Q_W-2:0]));
    end else begin
      over = |dq_q[DQ_W-1:Q_W-1];
    end
    if (over) begin
      q_mag = neg_q ? Q48_MIN : Q48_MAX;
    end else begin
      q_mag = dq_q[Q_W-1:0];
    end
  end

  // Sequence load, steps and final clamp
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    den_d  = den_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dq_d   = {num_mag, {FRAC_W{1'b0}}};
      den_d  = den_mag;
      neg_d  = req_i.num[Q_W] ^ req_i.den[Q_W-1];
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(DIV_STEPS)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        quo_d  = neg_q ? Q_W'(-q_mag) : q_mag;
      end else begin
        cnt_d = cnt_q + 1'b1;
        rem_d = fits ? diff[Q_W-1:0] : rem_sh[Q_W-1:0];
        dq_d  = {dq_q[DQ_W-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and working values
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    den_q <= den_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/ray_obb_slab_intersect.sv @@
// Ray versus oriented box slab test, one box axis per input transaction.
// A regular axis goes through accept, the shared 24x24 multiply-accumulate,
// the check, two divisions on the radix-2 divider and the update. A
// near-parallel axis skips the divisions, an axis of a missed box is only
// accepted. A new axis waits for the current one; the result is registered.
// Reset loads register defaults, clears the bounds and leaves no box open.
`default_nettype none

module ray_obb_slab_intersect (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [robb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [robb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  robb_axis_if.sink                       axis_in,
  robb_result_if.source                   result_out
);
  import robb_pkg::*;

  localparam int unsigned MCNT_W = $clog2(MUL_STEPS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV1 = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // Configuration registers
  q48_t             org_x_q, org_y_q, org_z_q;
  q48_t             dir_x_q, dir_y_q, dir_z_q;
  logic [EPS_W-1:0] eps_q;
  logic [FAR_W-1:0] far_lim_q;

  // Latched axis transaction
  q48_t ax_q, ay_q, az_q;
  q49_t dlt_x_q, dlt_y_q, dlt_z_q;
  q48_t lo_q, hi_q;
  logic last_q;

  // Sequencer and box state
  logic [2:0] state_q, state_d;
  q48_t       near_q, near_d;
  q48_t       far_q, far_d;
  logic       missed_q, missed_d;
  logic       open_q, open_d;

  // Multiply-accumulate
  logic [MCNT_W-1:0] mul_cnt_q, mul_cnt_d;
  logic [2*HALF_W-1:0] pp_q, pp_d;
  logic       pp_vld_q, pp_vld_d;
  logic       pp_neg_q, pp_neg_d;
  logic [1:0] pp_sh_q, pp_sh_d;
  logic       pp_end_q, pp_end_d;
  logic       pp_isf_q, pp_isf_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  q48_t       e_q, e_d;
  q48_t       f_q, f_d;
  q48_t       t1_q, t1_d;
  q48_t       t2_q, t2_d;

  // Result register
  logic out_vld_q, out_vld_d;
  logic hit_q, hit_d;
  q48_t entry_q, entry_d;

  robb_div_req_t div_req;
  robb_div_rsp_t div_rsp;

  logic              accept;
  q48_t              far_init;
  logic [2:0]        prod;
  logic [1:0]        part;
  q48_t              op_a;
  q49_t              op_b;
  logic [Q_W-1:0]    mag_a;
  logic [Q_W:0]      mag_b;
  logic [HALF_W-1:0] half_a, half_b;
  logic [ACC_W-1:0]  pp_shift, pp_term, acc_sum;
  logic [ACC_W-FRAC_W-1:0] acc_scaled;
  q48_t              dot_sat;
  q49_t              e_ext, lo_ext, hi_ext;
  q49_t              num_lo, num_hi, lo_m_e, hi_m_e;
  logic [Q_W-1:0]    f_mag;
  logic              parallel;
  q48_t              t_min, t_max, far_n, near_n;

  assign accept   = axis_in.valid & axis_in.ready;
  assign far_init = {1'b0, far_lim_q};

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q   <= '0;
      org_y_q   <= '0;
      org_z_q   <= '0;
      dir_x_q   <= '0;
      dir_y_q   <= '0;
      dir_z_q   <= DIR_Z_RST;
      eps_q     <= EPS_RST;
      far_lim_q <= FAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: org_x_q   <= cfg_data_i[Q_W-1:0];
        REG_ORIGIN_Y: org_y_q   <= cfg_data_i[Q_W-1:0];
        REG_ORIGIN_Z: org_z_q   <= cfg_data_i[Q_W-1:0];
        REG_DIR_X:    dir_x_q   <= cfg_data_i[Q_W-1:0];
        REG_DIR_Y:    dir_y_q   <= cfg_data_i[Q_W-1:0];
        REG_DIR_Z:    dir_z_q   <= cfg_data_i[Q_W-1:0];
        REG_EPSILON:  eps_q     <= cfg_data_i[EPS_W-1:0];
        REG_FAR:      far_lim_q <= cfg_data_i[FAR_W-1:0];
      endcase
    end
  end

  // Latch the axis and the offset from the ray origin
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q    <= axis_in.axis_x;
      ay_q    <= axis_in.axis_y;
      az_q    <= axis_in.axis_z;
      dlt_x_q <= {axis_in.box_pos_x[Q_W-1], axis_in.box_pos_x} - {org_x_q[Q_W-1], org_x_q};
      dlt_y_q <= {axis_in.box_pos_y[Q_W-1], axis_in.box_pos_y} - {org_y_q[Q_W-1], org_y_q};
      dlt_z_q <= {axis_in.box_pos_z[Q_W-1], axis_in.box_pos_z} - {org_z_q[Q_W-1], org_z_q};
      lo_q    <= axis_in.slab_low;
      hi_q    <= axis_in.slab_high;
      last_q  <= axis_in.last_axis;
    end
  end

  // Select the operands of the current partial product
  always_comb begin
    prod = mul_cnt_q[MCNT_W-1:2];
    part = mul_cnt_q[1:0];
    unique case (prod)
      3'd0:    begin op_a = ax_q;    op_b = dlt_x_q; end
      3'd1:    begin op_a = ay_q;    op_b = dlt_y_q; end
      3'd2:    begin op_a = az_q;    op_b = dlt_z_q; end
      3'd3:    begin op_a = dir_x_q; op_b = {ax_q[Q_W-1], ax_q}; end
      3'd4:    begin op_a = dir_y_q; op_b = {ay_q[Q_W-1], ay_q}; end
      default: begin op_a = dir_z_q; op_b = {az_q[Q_W-1], az_q}; end
    endcase
    mag_a  = op_a[Q_W-1] ? Q_W'(-op_a) : op_a;
    mag_b  = op_b[Q_W] ? (Q_W+1)'(-op_b) : op_b;
    half_a = part[1] ? mag_a[Q_W-1:HALF_W] : mag_a[HALF_W-1:0];
    half_b = part[0] ? mag_b[Q_W-1:HALF_W] : mag_b[HALF_W-1:0];
  end

  // Issue one 24x24 partial product per cycle
  always_comb begin
    pp_vld_d = (state_q == S_MUL) && (mul_cnt_q < MCNT_W'(MUL_STEPS));
    pp_d     = half_a * half_b;
    pp_neg_d = op_a[Q_W-1] ^ op_b[Q_W];
    pp_sh_d  = {1'b0, part[1]} + {1'b0, part[0]};
    pp_end_d = (part == 2'd3) && ((prod == 3'd2) || (prod == 3'd5));
    pp_isf_d = prod >= 3'd3;
  end

  // Accumulate the registered partial product, floor-shift and clamp
  always_comb begin
    pp_shift   = {{(ACC_W-2*HALF_W){1'b0}}, pp_q} << (pp_sh_q * HALF_W);
    pp_term    = pp_neg_q ? ACC_W'(-pp_shift) : pp_shift;
    acc_sum    = acc_q + pp_term;
    acc_scaled = acc_sum[ACC_W-1:FRAC_W];
    if ((&acc_scaled[ACC_W-FRAC_W-1:Q_W-1]) || ~(|acc_scaled[ACC_W-FRAC_W-1:Q_W-1])) begin
      dot_sat = acc_scaled[Q_W-1:0];
    end else begin
      dot_sat = acc_scaled[ACC_W-FRAC_W-1] ? Q48_MIN : Q48_MAX;
    end
  end

  // Numerators, containment differences and the parallel test
  always_comb begin
    e_ext    = {e_q[Q_W-1], e_q};
    lo_ext   = {lo_q[Q_W-1], lo_q};
    hi_ext   = {hi_q[Q_W-1], hi_q};
    num_lo   = e_ext + lo_ext;
    num_hi   = e_ext + hi_ext;
    lo_m_e   = lo_ext - e_ext;
    hi_m_e   = hi_ext - e_ext;
    f_mag    = f_q[Q_W-1] ? Q_W'(-f_q) : f_q;
    parallel = !(f_mag > {{(Q_W-EPS_W){1'b0}}, eps_q});
  end

  // Order the plane distances and narrow the interval
  always_comb begin
    t_min  = (t1_q > t2_q) ? t2_q : t1_q;
    t_max  = (t1_q > t2_q) ? t1_q : t2_q;
    far_n  = (t_max < far_q) ? t_max : far_q;
    near_n = (t_min > near_q) ? t_min : near_q;
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    near_d    = near_q;
    far_d     = far_q;
    missed_d  = missed_q;
    open_d    = open_q;
    mul_cnt_d = mul_cnt_q;
    acc_d     = acc_q;
    e_d       = e_q;
    f_d       = f_q;
    t1_d      = t1_q;
    t2_d      = t2_q;
    hit_d     = hit_q;
    entry_d   = entry_q;
    out_vld_d = out_vld_q & ~result_out.ready;
    div_req.start = 1'b0;
    div_req.num   = num_lo;
    div_req.den   = f_q;

    unique case (state_q)
      S_IDLE: begin
        if (axis_in.valid) begin
          open_d = 1'b1;
          if (!open_q) begin
            near_d   = '0;
            far_d    = far_init;
            missed_d = 1'b0;
          end
          if (open_q && missed_q) begin
            state_d = axis_in.last_axis ? S_FIN : S_IDLE;
          end else begin
            state_d   = S_MUL;
            mul_cnt_d = '0;
            acc_d     = '0;
          end
        end
      end
      S_MUL: begin
        mul_cnt_d = mul_cnt_q + 1'b1;
        if (pp_vld_q) begin
          if (pp_end_q) begin
            acc_d = '0;
            if (pp_isf_q) begin
              f_d = dot_sat;
            end else begin
              e_d = dot_sat;
            end
          end else begin
            acc_d = acc_sum;
          end
        end
        if (mul_cnt_q == MCNT_W'(MUL_STEPS)) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (parallel) begin
          if ((!lo_m_e[Q_W] && (lo_m_e != '0)) || hi_m_e[Q_W]) begin
            missed_d = 1'b1;
          end
          state_d = last_q ? S_FIN : S_IDLE;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          t1_d          = div_rsp.quo;
          div_req.start = 1'b1;
          div_req.num   = num_hi;
          state_d       = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          t2_d    = div_rsp.quo;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        far_d  = far_n;
        near_d = near_n;
        if (near_n > far_n) begin
          missed_d = 1'b1;
        end
        state_d = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        // Wait for the result register, then close the box
        if (!out_vld_q || result_out.ready) begin
          out_vld_d = 1'b1;
          hit_d     = ~missed_q;
          entry_d   = missed_q ? '0 : near_q;
          near_d    = '0;
          far_d     = far_init;
          missed_d  = 1'b0;
          open_d    = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  robb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      near_q    <= '0;
      far_q     <= {1'b0, FAR_RST};
      missed_q  <= 1'b0;
      open_q    <= 1'b0;
      mul_cnt_q <= '0;
      pp_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      near_q    <= near_d;
      far_q     <= far_d;
      missed_q  <= missed_d;
      open_q    <= open_d;
      mul_cnt_q <= mul_cnt_d;
      pp_vld_q  <= pp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pp_q     <= pp_d;
    pp_neg_q <= pp_neg_d;
    pp_sh_q  <= pp_sh_d;
    pp_end_q <= pp_end_d;
    pp_isf_q <= pp_isf_d;
    acc_q    <= acc_d;
    e_q      <= e_d;
    f_q      <= f_d;
    t1_q     <= t1_d;
    t2_q     <= t2_d;
    hit_q    <= hit_d;
    entry_q  <= entry_d;
  end

  assign axis_in.ready             = (state_q == S_IDLE);
  assign result_out.valid          = out_vld_q;
  assign result_out.hit            = hit_q;
  assign result_out.entry_distance = entry_q;

endmodule

`default_nettype wire
